### rtl/lqr_pendulum_state_feedback_defines.svh
// Assertion shorthands shared by the checker files.
// Every check is sampled on the rising clock edge and switched off while rst_n is low.
`ifndef LQR_PENDULUM_STATE_FEEDBACK_DEFINES_SVH
`define LQR_PENDULUM_STATE_FEEDBACK_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPSF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpsf: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LPSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpsf: next-cycle check failed");

`endif

### rtl/lpsf_pkg.sv
`timescale 1ns / 1ps

package lpsf_pkg;

  localparam int AngleW    = 32;
  localparam int DiffW     = AngleW + 1;
  localparam int DtW       = 20;
  localparam int GainW     = 24;
  localparam int WinW      = 31;
  localparam int LimitW    = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 31;
  localparam int MulAW     = 34;
  localparam int ProdW     = 58;
  localparam int QuoW      = 33;
  localparam int MacTerms  = 4;
  localparam int CntW      = 6;
  localparam int InTdataW  = 88;
  localparam int OutTdataW = 24;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CFG_GAIN_MA   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_PA   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_MS   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GAIN_PS   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW    = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT     = 3'd5;

  // Terms of the feedback sum, in multiply order
  localparam logic [1:0] TERM_MA = 2'd0;
  localparam logic [1:0] TERM_PA = 2'd1;
  localparam logic [1:0] TERM_MS = 2'd2;
  localparam logic [1:0] TERM_PS = 2'd3;

  localparam logic signed [GainW-1:0] UsPerS = 24'sd1000000;

  localparam logic signed [GainW-1:0] GAIN_MA_RST = -24'sd655360;
  localparam logic signed [GainW-1:0] GAIN_PA_RST = 24'sd7098479;
  localparam logic signed [GainW-1:0] GAIN_MS_RST = -24'sd260846;
  localparam logic signed [GainW-1:0] GAIN_PS_RST = 24'sd127906;
  localparam logic [WinW-1:0]         WINDOW_RST  = 31'd34315;
  localparam logic [LimitW-1:0]       LIMIT_RST   = 16'd65535;

  typedef struct packed {
    logic       capture;
    logic       mul_en;
    logic       mul_scale;
    logic [1:0] term;
    logic       sel;
    logic       div_load;
    logic       div_step;
    logic       speed_store;
    logic       acc_en;
    logic       finish;
    logic       zero_result;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic in_window;
    logic primed;
  } sts_t;

endpackage

### rtl/lpsf_ctrl.sv
`timescale 1ns / 1ps

module lpsf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  lpsf_pkg::sts_t    sts,
  output lpsf_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_SCALE = 4'd2;
  localparam logic [3:0] S_PRE   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_SPEED = 4'd5;
  localparam logic [3:0] S_MAC   = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0]                state_r, state_nxt;
  logic [lpsf_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic                      sel_r, sel_nxt;
  logic                      out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    cmd           = '0;
    cmd.sel       = sel_r;
    cmd.term      = cnt_r[1:0];
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!sts.in_window) begin
          cmd.zero_result = 1'b1;
          state_nxt       = S_OUT;
        end else if (!sts.primed) begin
          cnt_nxt   = '0;
          state_nxt = S_MAC;
        end else begin
          sel_nxt   = 1'b0;
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd.mul_en    = 1'b1;
        cmd.mul_scale = 1'b1;
        state_nxt     = S_PRE;
      end
      S_PRE: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == lpsf_pkg::CntW'(lpsf_pkg::QuoW - 1)) begin
          state_nxt = S_SPEED;
        end
      end
      S_SPEED: begin
        cmd.speed_store = 1'b1;
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = S_SCALE;
        end else begin
          cnt_nxt   = '0;
          state_nxt = S_MAC;
        end
      end
      S_MAC: begin
        // multiply one term per cycle, accumulate the one before it
        cmd.mul_en = (cnt_r < lpsf_pkg::CntW'(lpsf_pkg::MacTerms));
        cmd.acc_en = (cnt_r != '0);
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == lpsf_pkg::CntW'(lpsf_pkg::MacTerms)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

### rtl/lpsf_datapath.sv
`timescale 1ns / 1ps

module lpsf_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [lpsf_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [lpsf_pkg::CfgDataW-1:0]       cfg_data,
  input  logic signed [lpsf_pkg::AngleW-1:0]  pendulum_angle,
  input  logic signed [lpsf_pkg::AngleW-1:0]  motor_angle,
  input  logic [lpsf_pkg::DtW-1:0]            elapsed_us,
  input  lpsf_pkg::cmd_t                      cmd,
  output lpsf_pkg::sts_t                      sts,
  output logic                                drive_enable,
  output logic                                direction,
  output logic [lpsf_pkg::LimitW-1:0]         drive_magnitude
);

  // configuration
  logic signed [lpsf_pkg::GainW-1:0] gain_ma_r, gain_pa_r, gain_ms_r, gain_ps_r;
  logic [lpsf_pkg::WinW-1:0]         window_r;
  logic [lpsf_pkg::LimitW-1:0]       limit_r;

  // sample state
  logic signed [lpsf_pkg::AngleW-1:0] last_pa_r, last_ma_r;
  logic                               primed_r, primed_snap_r, win_r;
  logic signed [lpsf_pkg::AngleW-1:0] pa_r, ma_r, speed_p_r, speed_m_r;
  logic [lpsf_pkg::DtW-1:0]           dt_r;
  logic signed [lpsf_pkg::DiffW-1:0]  diff_p_r, diff_m_r;

  // shared multiplier, divider and accumulator
  logic signed [lpsf_pkg::ProdW-1:0]  mul_r, acc_r;
  logic [lpsf_pkg::DtW-1:0]           rem_r;
  logic [lpsf_pkg::QuoW-1:0]          divd_r;
  logic                               sat_r, neg_r;

  logic                               res_en_r, res_dir_r;
  logic [lpsf_pkg::LimitW-1:0]        res_mag_r;

  logic signed [lpsf_pkg::DiffW-1:0]  pa_ext, pa_abs;
  logic signed [lpsf_pkg::DiffW-1:0]  diff_sel, diff_abs;
  logic signed [lpsf_pkg::MulAW-1:0]  mul_a;
  logic signed [lpsf_pkg::GainW-1:0]  mul_b;
  logic [lpsf_pkg::DtW:0]             rem_sh, rem_sub;
  logic                               div_ge;
  logic                               pos_big, neg_big;
  logic signed [lpsf_pkg::AngleW-1:0] speed_val;
  logic [lpsf_pkg::ProdW-1:0]         acc_abs;
  logic [lpsf_pkg::ProdW-33:0]        mag_hi;
  logic [lpsf_pkg::LimitW-1:0]        mag_sat;

  assign sts.in_window = win_r;
  assign sts.primed    = primed_snap_r;

  assign pa_ext = {pendulum_angle[lpsf_pkg::AngleW-1], pendulum_angle};
  assign pa_abs = pa_ext[lpsf_pkg::DiffW-1] ? -pa_ext : pa_ext;

  assign diff_sel = cmd.sel ? diff_m_r : diff_p_r;
  assign diff_abs = diff_sel[lpsf_pkg::DiffW-1] ? -diff_sel : diff_sel;

  always_comb begin
    if (cmd.mul_scale) begin
      mul_a = {2'b00, diff_abs[lpsf_pkg::AngleW-1:0]};
      mul_b = lpsf_pkg::UsPerS;
    end else begin
      case (cmd.term)
        lpsf_pkg::TERM_MA: begin
          mul_a = {{2{ma_r[lpsf_pkg::AngleW-1]}}, ma_r};
          mul_b = gain_ma_r;
        end
        lpsf_pkg::TERM_PA: begin
          mul_a = {{2{pa_r[lpsf_pkg::AngleW-1]}}, pa_r};
          mul_b = gain_pa_r;
        end
        lpsf_pkg::TERM_MS: begin
          mul_a = {{2{speed_m_r[lpsf_pkg::AngleW-1]}}, speed_m_r};
          mul_b = gain_ms_r;
        end
        default: begin
          mul_a = {{2{speed_p_r[lpsf_pkg::AngleW-1]}}, speed_p_r};
          mul_b = gain_ps_r;
        end
      endcase
    end
  end

  // restoring division, one quotient bit per cycle
  assign rem_sh  = {rem_r, divd_r[lpsf_pkg::QuoW-1]};
  assign div_ge  = (rem_sh >= {1'b0, dt_r});
  assign rem_sub = rem_sh - {1'b0, dt_r};

  // clamp quotient to 32-bit signed
  assign pos_big = sat_r | divd_r[32] | divd_r[31];
  assign neg_big = sat_r | divd_r[32] | (divd_r[31] & (|divd_r[30:0]));
  always_comb begin
    if (neg_r) begin
      speed_val = neg_big ? 32'sh8000_0000 : -$signed(divd_r[31:0]);
    end else begin
      speed_val = pos_big ? 32'sh7fff_ffff : $signed(divd_r[31:0]);
    end
  end

  assign acc_abs = acc_r[lpsf_pkg::ProdW-1] ? 58'(-acc_r) : 58'(acc_r);
  assign mag_hi  = acc_abs[lpsf_pkg::ProdW-1:32];
  assign mag_sat = (mag_hi > {10'd0, limit_r}) ? limit_r : mag_hi[lpsf_pkg::LimitW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_ma_r <= lpsf_pkg::GAIN_MA_RST;
      gain_pa_r <= lpsf_pkg::GAIN_PA_RST;
      gain_ms_r <= lpsf_pkg::GAIN_MS_RST;
      gain_ps_r <= lpsf_pkg::GAIN_PS_RST;
      window_r  <= lpsf_pkg::WINDOW_RST;
      limit_r   <= lpsf_pkg::LIMIT_RST;
      last_pa_r <= '0;
      last_ma_r <= '0;
      primed_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          lpsf_pkg::CFG_GAIN_MA: gain_ma_r <= cfg_data[lpsf_pkg::GainW-1:0];
          lpsf_pkg::CFG_GAIN_PA: gain_pa_r <= cfg_data[lpsf_pkg::GainW-1:0];
          lpsf_pkg::CFG_GAIN_MS: gain_ms_r <= cfg_data[lpsf_pkg::GainW-1:0];
          lpsf_pkg::CFG_GAIN_PS: gain_ps_r <= cfg_data[lpsf_pkg::GainW-1:0];
          lpsf_pkg::CFG_WINDOW:  window_r  <= cfg_data[lpsf_pkg::WinW-1:0];
          lpsf_pkg::CFG_LIMIT:   limit_r   <= cfg_data[lpsf_pkg::LimitW-1:0];
          default: ;
        endcase
      end
      if (cmd.capture) begin
        last_pa_r <= pendulum_angle;
        last_ma_r <= motor_angle;
        primed_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pa_r          <= pendulum_angle;
      ma_r          <= motor_angle;
      dt_r          <= (elapsed_us == '0) ? lpsf_pkg::DtW'(1) : elapsed_us;
      diff_p_r      <= pa_ext - {last_pa_r[lpsf_pkg::AngleW-1], last_pa_r};
      diff_m_r      <= {motor_angle[lpsf_pkg::AngleW-1], motor_angle}
                       - {last_ma_r[lpsf_pkg::AngleW-1], last_ma_r};
      primed_snap_r <= primed_r;
      win_r         <= (pa_abs < {2'b00, window_r});
      speed_p_r     <= '0;
      speed_m_r     <= '0;
      acc_r         <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + mul_r;
    end
    if (cmd.mul_en) begin
      mul_r <= mul_a * mul_b;
    end
    if (cmd.mul_scale) begin
      neg_r <= diff_sel[lpsf_pkg::DiffW-1];
    end
    if (cmd.div_load) begin
      // high part at or above the divisor means the quotient cannot fit 33 bits
      sat_r  <= ({1'b0, mul_r[51:33]} >= dt_r);
      rem_r  <= {1'b0, mul_r[51:33]};
      divd_r <= mul_r[lpsf_pkg::QuoW-1:0];
    end else if (cmd.div_step) begin
      rem_r  <= div_ge ? rem_sub[lpsf_pkg::DtW-1:0] : rem_sh[lpsf_pkg::DtW-1:0];
      divd_r <= {divd_r[lpsf_pkg::QuoW-2:0], div_ge};
    end
    if (cmd.speed_store) begin
      if (cmd.sel) begin
        speed_m_r <= speed_val;
      end else begin
        speed_p_r <= speed_val;
      end
    end
    if (cmd.zero_result) begin
      res_en_r  <= 1'b0;
      res_dir_r <= 1'b0;
      res_mag_r <= '0;
    end else if (cmd.finish) begin
      res_en_r  <= 1'b1;
      res_dir_r <= ~acc_r[lpsf_pkg::ProdW-1] & (|acc_r);
      res_mag_r <= mag_sat;
    end
    if (cmd.out_load) begin
      drive_enable    <= res_en_r;
      direction       <= res_dir_r;
      drive_magnitude <= res_mag_r;
    end
  end

endmodule

### rtl/lqr_pendulum_state_feedback.sv
`timescale 1ns / 1ps

// LQR balance controller: each input transaction carries the pendulum and motor
// angles (signed Q16.16 rad) and the microseconds since the previous sample, and
// yields one output transaction with the motor enable, direction and saturated
// drive level. One sample is processed at a time. For a sample inside the angle
// window, the shared restoring divider forms the two speeds one after the other
// (33 quotient bits each), followed by four passes through the shared 34x24
// multiplier for the feedback sum. The first sample after reset skips the speeds;
// a sample outside the window skips both and yields a zero result. The next sample
// can be accepted in the same cycle that the result is presented. A finished
// result waits in the output register while the next sample is accepted. Gains and
// limits must be written by the user through cfg_* only while the block is idle,
// one register per cycle, and then take effect on the next sample; the block
// itself does not enforce this.
module lqr_pendulum_state_feedback (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [31:0] pendulum_angle, [63:32] motor_angle, [83:64] elapsed_us, [87:84] zero
  input  logic [lpsf_pkg::InTdataW-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] drive_enable, [1] direction, [17:2] drive_magnitude, [23:18] zero
  output logic [lpsf_pkg::OutTdataW-1:0]    out_tdata,
  input  logic                              cfg_we,
  input  logic [lpsf_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [lpsf_pkg::CfgDataW-1:0]     cfg_data
);

  lpsf_pkg::cmd_t                  cmd;
  lpsf_pkg::sts_t                  sts;
  logic                            drive_enable;
  logic                            direction;
  logic [lpsf_pkg::LimitW-1:0]     drive_magnitude;

  lpsf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  lpsf_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .pendulum_angle  (in_tdata[31:0]),
    .motor_angle     (in_tdata[63:32]),
    .elapsed_us      (in_tdata[83:64]),
    .cmd             (cmd),
    .sts             (sts),
    .drive_enable    (drive_enable),
    .direction       (direction),
    .drive_magnitude (drive_magnitude)
  );

  assign out_tdata = {6'd0, drive_magnitude, direction, drive_enable};

endmodule

### rtl/lpsf_checker.sv
`timescale 1ns / 1ps
`include "lqr_pendulum_state_feedback_defines.svh"

module lpsf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [lpsf_pkg::OutTdataW-1:0]    out_tdata
);

  // a stalled result stays put
  `LPSF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // one sample in flight: no back-to-back acceptance
  `LPSF_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready)

  // a stopped motor reports no direction and no drive
  `LPSF_ASSERT_SAME(a_stop_quiet, out_tvalid && !out_tdata[0], out_tdata[17:1] == 17'd0)

endmodule

bind lqr_pendulum_state_feedback lpsf_checker u_lpsf_checker (.*);
